// File: design/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Types, codes and helper functions shared by the ADC frame deframer blocks.
// ----------------------------------------------------------------------------
package afd_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;
    localparam int POS_W       = 6;
    localparam int LEN_W       = 7;
    localparam int WIDX_W      = 5;

    localparam logic [POS_W-1:0] POS_MAX  = 6'd63;
    localparam logic [15:0]      CRC_INIT = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY = 16'h1021;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WORD_SIZE = 1'b0,
        CFG_CRC_EN    = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        WS_16 = 2'd0,
        WS_24 = 2'd1,
        WS_32 = 2'd2
    } word_size_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_CRC    = 2'd2
    } err_code_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_FETCH,
        EM_SHOW,
        EM_ERROR
    } emit_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } rx_beat_t;

    typedef struct packed {
        logic [2:0]         channel_index;
        logic signed [23:0] sample_value;
        logic [31:0]        status_word;
        logic [1:0]         error_code;
        logic               last_of_frame;
    } result_beat_t;

    typedef struct packed {
        logic        valid;
        err_code_t   code;
        logic [31:0] status;
    } frame_done_t;

    function automatic logic [2:0] bytes_per_word(input logic [1:0] wsel);
        logic [2:0] nb;
        unique case (wsel)
            WS_16:   nb = 3'd2;
            WS_24:   nb = 3'd3;
            default: nb = 3'd4;
        endcase
        return nb;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Rounds a 32-bit word toward zero when it drops the low byte.
    function automatic logic [23:0] normalise(input logic [31:0] w,
                                              input logic [1:0]  wsel);
        logic [31:0] t;
        logic [23:0] r;
        t = w + (w[31] ? 32'd255 : 32'd0);
        unique case (wsel)
            WS_16:   r = {w[15:0], 8'h00};
            WS_24:   r = w[23:0];
            default: r = t[31:8];
        endcase
        return r;
    endfunction

endpackage

// File: design/afd_stream_if.sv
// ----------------------------------------------------------------------------
// afd_stream_if
// Valid/ready channel that carries one beat of the given payload type.
// ----------------------------------------------------------------------------
interface afd_stream_if #(
    parameter type beat_t = logic
);
    logic  valid;
    logic  ready;
    beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/afd_byte_decoder.sv
// ----------------------------------------------------------------------------
// afd_byte_decoder
// Assembles frame words, runs the CRC, writes channel samples to the sample
// memory and reports the frame verdict on the last byte.
// ----------------------------------------------------------------------------
module afd_byte_decoder #(
    parameter int CHANNELS = 8,
    parameter int AW       = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [afd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [afd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               beat_ok,
    input  afd_pkg::rx_beat_t                  beat,
    output logic                               mem_we,
    output logic [AW-1:0]                      mem_waddr,
    output logic [23:0]                        mem_wdata,
    output afd_pkg::frame_done_t               done
);

    localparam int WORDS = 1 + CHANNELS;

    logic [1:0]                 wsel_reg;
    logic                       crc_en_reg;
    logic [afd_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [31:0]                acc_reg, acc_next;
    logic [15:0]                crc_reg, crc_next;
    logic [31:0]                status_reg, status_next;

    logic [2:0]                 wb;
    logic [afd_pkg::LEN_W-1:0]  crc_span;
    logic [afd_pkg::LEN_W-1:0]  expected;
    logic [afd_pkg::WIDX_W-1:0] widx;
    logic [1:0]                 inw;
    logic [13:0]                div3;
    logic [afd_pkg::POS_W-1:0]  q3;
    logic                       decode;
    logic                       word_done;
    logic [afd_pkg::POS_W-1:0]  count;
    afd_pkg::err_code_t         code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsel_reg   <= afd_pkg::WS_24;
            crc_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                afd_pkg::CFG_WORD_SIZE: wsel_reg   <= cfg_data;
                afd_pkg::CFG_CRC_EN:    crc_en_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        wb       = afd_pkg::bytes_per_word(wsel_reg);
        crc_span = 7'(7'(wb) * 7'(WORDS));
        expected = 7'(7'(wb) * 7'(WORDS + {31'd0, crc_en_reg}));
        div3     = 14'(14'(pos_reg) * 14'd171);
        q3       = 6'(div3 >> 9);
        unique case (wsel_reg)
            afd_pkg::WS_16:
            begin
                widx = 5'(pos_reg >> 1);
                inw  = {1'b0, pos_reg[0]};
            end
            afd_pkg::WS_24:
            begin
                widx = 5'(q3);
                inw  = 2'(pos_reg - 6'(q3 * 6'd3));
            end
            default:
            begin
                widx = 5'(pos_reg >> 2);
                inw  = pos_reg[1:0];
            end
        endcase

        decode = ({1'b0, pos_reg} < expected) && (pos_reg != afd_pkg::POS_MAX);

        crc_next = crc_reg;
        if (decode && ({1'b0, pos_reg} < crc_span))
            crc_next = afd_pkg::crc_update(crc_reg, beat.data_byte);

        acc_next = acc_reg;
        if (decode)
            acc_next = (inw == 2'd0) ? {24'd0, beat.data_byte}
                                     : {acc_reg[23:0], beat.data_byte};

        word_done   = decode && ({1'b0, inw} == wb - 3'd1);
        status_next = (word_done && widx == '0) ? acc_next : status_reg;

        mem_we    = beat_ok && word_done && (widx != '0) && (widx <= 5'(CHANNELS));
        mem_waddr = AW'(widx - 5'd1);
        mem_wdata = afd_pkg::normalise(acc_next, wsel_reg);

        count = (pos_reg == afd_pkg::POS_MAX) ? afd_pkg::POS_MAX : pos_reg + 6'd1;

        if ({1'b0, count} != expected)
            code = afd_pkg::ERR_LENGTH;
        else if (crc_en_reg && (crc_next != acc_next[15:0]))
            code = afd_pkg::ERR_CRC;
        else
            code = afd_pkg::ERR_NONE;

        done.valid  = beat_ok && beat.frame_end;
        done.code   = code;
        done.status = status_next;

        pos_next = count;
        if (beat.frame_end)
        begin
            pos_next = '0;
            acc_next = '0;
            crc_next = afd_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            acc_reg    <= '0;
            crc_reg    <= afd_pkg::CRC_INIT;
            status_reg <= '0;
        end
        else if (beat_ok)
        begin
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            crc_reg    <= crc_next;
            status_reg <= status_next;
        end
    end

endmodule

// File: design/afd_result_emitter.sv
// ----------------------------------------------------------------------------
// afd_result_emitter
// Holds the sample memory and sends the frame's results, one channel beat
// after another, or a single error beat.
// ----------------------------------------------------------------------------
module afd_result_emitter #(
    parameter int CHANNELS = 8,
    parameter int AW       = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        mem_we,
    input  logic [AW-1:0]               mem_waddr,
    input  logic [23:0]                 mem_wdata,
    input  afd_pkg::frame_done_t        done,
    output logic                        idle,
    output logic                        out_valid,
    input  logic                        out_ready,
    output afd_pkg::result_beat_t       out_beat
);

    localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);

    logic [23:0]            mem [CHANNELS];
    logic [23:0]            rdata_reg;
    afd_pkg::emit_state_t   state_reg, state_next;
    logic [AW-1:0]          ch_reg, ch_next;
    afd_pkg::err_code_t     code_reg;
    logic [31:0]            status_reg;
    logic                   last_ch;

    assign last_ch = (ch_reg == LAST_CH);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == afd_pkg::EM_FETCH)
            rdata_reg <= mem[ch_reg];
    end

    always_ff @(posedge clk)
    begin
        if (done.valid)
        begin
            code_reg   <= done.code;
            status_reg <= done.status;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        unique case (state_reg)
            afd_pkg::EM_IDLE:
            begin
                if (done.valid)
                begin
                    ch_next    = '0;
                    state_next = (done.code != afd_pkg::ERR_NONE) ? afd_pkg::EM_ERROR
                                                                  : afd_pkg::EM_FETCH;
                end
            end
            afd_pkg::EM_FETCH:
                state_next = afd_pkg::EM_SHOW;
            afd_pkg::EM_SHOW:
            begin
                if (out_ready)
                begin
                    if (last_ch)
                        state_next = afd_pkg::EM_IDLE;
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = afd_pkg::EM_FETCH;
                    end
                end
            end
            afd_pkg::EM_ERROR:
            begin
                if (out_ready)
                    state_next = afd_pkg::EM_IDLE;
            end
            default:
                state_next = afd_pkg::EM_IDLE;
        endcase
    end

    always_comb
    begin
        idle      = (state_reg == afd_pkg::EM_IDLE);
        out_valid = 1'b0;
        out_beat  = '0;
        unique case (state_reg)
            afd_pkg::EM_SHOW:
            begin
                out_valid              = 1'b1;
                out_beat.channel_index = 3'(ch_reg);
                out_beat.sample_value  = rdata_reg;
                out_beat.status_word   = status_reg;
                out_beat.error_code    = afd_pkg::ERR_NONE;
                out_beat.last_of_frame = last_ch;
            end
            afd_pkg::EM_ERROR:
            begin
                out_valid              = 1'b1;
                out_beat.error_code    = code_reg;
                out_beat.last_of_frame = 1'b1;
            end
            default:
                out_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= afd_pkg::EM_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    a_verdict_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done.valid |-> state_reg == afd_pkg::EM_IDLE)
        else $error("Frame verdict arrived while results were still pending.");

    a_no_input_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !idle)
        else $error("Input side open while a result beat is pending.");

    a_error_path: assert property (@(posedge clk) disable iff (!rst_n)
        (done.valid && done.code != afd_pkg::ERR_NONE) |=> state_reg == afd_pkg::EM_ERROR)
        else $error("Bad frame did not lead to an error beat.");

    a_good_path: assert property (@(posedge clk) disable iff (!rst_n)
        (done.valid && done.code == afd_pkg::ERR_NONE)
            |=> state_reg == afd_pkg::EM_FETCH && ch_reg == '0)
        else $error("Good frame did not start the burst at channel zero.");

    a_burst_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_beat.last_of_frame) |=> state_reg == afd_pkg::EM_IDLE)
        else $error("Emitter did not return to idle after the last beat.");

endmodule

// File: design/adc_frame_deframer_crc_check.sv
// ----------------------------------------------------------------------------
// adc_frame_deframer_crc_check
// Order: once the frame's last byte is accepted, each channel beat of a good
// frame is read from memory (EM_FETCH) and then shown (EM_SHOW) until taken; a
// bad frame gives a single error beat (EM_ERROR), shown in the cycle after.
// Throughput: one byte per cycle while no results are pending; input stalls
// while a frame's results are being sent. Reset clears the frame state,
// selects 24-bit words with the CRC check off; the sample memory is not cleared.
// ----------------------------------------------------------------------------
module adc_frame_deframer_crc_check #(
    parameter int CHANNELS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [afd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [afd_pkg::CFG_DATA_W-1:0]     cfg_data,
    afd_stream_if.sink                         rx,
    afd_stream_if.source                       result
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                  beat_ok;
    logic                  idle;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [23:0]           mem_wdata;
    afd_pkg::frame_done_t  done;

    assign rx.ready = idle;
    assign beat_ok  = rx.valid && idle;

    afd_byte_decoder #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .beat_ok   (beat_ok),
        .beat      (rx.payload),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .done      (done)
    );

    afd_result_emitter #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .done      (done),
        .idle      (idle),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_beat  (result.payload)
    );

endmodule
